/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh - concurrent assertion helpers
// Shorthand for clocked, reset-gated checks on clk / rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LVFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define LVFS_ASSERT_IMPL(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

`endif

/* rtl/lvfs_pkg.sv */
// ----------------------------------------------------------------------------
// lvfs_pkg - shared types and constants of the focus score unit
// Geometry constants, register indexes and the classified-pixel item.
// ----------------------------------------------------------------------------
`default_nettype none
package lvfs_pkg;

  localparam int LVFS_SPAN     = 96;
  localparam int LVFS_SLOTS    = 2 * LVFS_SPAN;
  localparam int LVFS_DIM_MAX  = 8192;
  localparam int LVFS_POS_W    = 13;
  localparam int LVFS_K_W      = 8;
  localparam int LVFS_STEP_W   = 6;
  localparam int LVFS_ADDR_W   = 9;
  localparam int LVFS_DEPTH    = 2 * LVFS_SLOTS;
  // 2^20 / 96 rounded up: exact quotient for every crop length below 8192
  localparam int LVFS_RECIP    = 10923;
  localparam int LVFS_RECIP_SH = 20;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MIN_SAMPLES  = 2'd2;

  // One classified pixel, front to back
  typedef struct packed {
    logic [7:0]          pix;
    logic [LVFS_K_W-1:0] kx;
    logic                row_sel;  // parity of the lattice row
    logic                wr;       // store the pixel in the lattice row
    logic                smp;      // form a Laplacian sample
    logic                clr;      // first pixel of a frame
    logic                last;     // last pixel of a frame
  } lvfs_item_t;

  // Clamp a dimension register into 1..8192
  function automatic logic [13:0] lvfs_clamp(input logic [13:0] v);
    if (v == 14'd0) return 14'd1;
    if (v > 14'(LVFS_DIM_MAX)) return 14'(LVFS_DIM_MAX);
    return v;
  endfunction

  // Lattice step max(1, len/96) by reciprocal multiply
  function automatic logic [LVFS_STEP_W-1:0] lvfs_step(input logic [12:0] len);
    logic [26:0] p;
    logic [6:0]  q;
    p = 27'(len) * 27'(LVFS_RECIP);
    q = p[26:LVFS_RECIP_SH];
    if (q == 7'd0) return LVFS_STEP_W'(1);
    return q[LVFS_STEP_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/lvfs_front.sv */
// ----------------------------------------------------------------------------
// lvfs_front - pixel position tracking and lattice classification
// Walks the raster, marks lattice points and samples, pushes one item per pixel.
// ----------------------------------------------------------------------------
`default_nettype none
module lvfs_front import lvfs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [13:0] frame_width,
  input  wire logic [13:0] frame_height,
  input  wire logic        cfg_wr,
  input  wire logic        in_valid,
  input  wire logic [7:0]  in_pix,
  input  wire logic        in_start,
  input  wire logic        q_full,
  output logic             in_ready,
  output logic             push,
  output lvfs_item_t       push_item
);

  logic [13:0]            wc, hc;
  logic [12:0]            start_x, len_x, wm1, start_y, len_y, hm1;
  logic [LVFS_STEP_W-1:0] step_x, step_y;
  logic                   geo_stale;

  logic [LVFS_POS_W-1:0]  col, row, col_e, row_e, off_x, off_y;
  logic [LVFS_STEP_W-1:0] ph_x, ph_y, ph_xe, ph_ye, ph_x_next, ph_y_next;
  logic [LVFS_K_W-1:0]    k_x, k_y, k_xe, k_ye, k_x_next, k_y_next;
  logic                   in_x, in_y, on_x, on_y, line_end, frame_end;
  logic [13:0]            reach_x;

  // Register the crop geometry from the configuration
  assign wc = lvfs_clamp(frame_width);
  assign hc = lvfs_clamp(frame_height);
  always_ff @(posedge clk) begin
    start_x <= 13'(wc[13:2]);
    len_x   <= wc[13:1];
    wm1     <= 13'(wc - 14'd1);
    step_x  <= lvfs_step(wc[13:1]);
    start_y <= 13'(hc[13:2]);
    len_y   <= hc[13:1];
    hm1     <= 13'(hc - 14'd1);
    step_y  <= lvfs_step(hc[13:1]);
  end

  // Hold the input for the cycle in which the geometry catches up with a write
  always_ff @(posedge clk) begin
    if (rst) begin
      geo_stale <= 1'b0;
    end else begin
      geo_stale <= cfg_wr;
    end
  end

  assign in_ready = !q_full && !geo_stale;
  assign push     = in_valid && in_ready;

  // Effective position: a frame start counts as (0,0)
  always_comb begin
    col_e = in_start ? '0 : col;
    row_e = in_start ? '0 : row;
    ph_xe = in_start ? '0 : ph_x;
    ph_ye = in_start ? '0 : ph_y;
    k_xe  = in_start ? '0 : k_x;
    k_ye  = in_start ? '0 : k_y;
  end

  // Classify against the crop lattice
  always_comb begin
    off_x   = col_e - start_x;
    off_y   = row_e - start_y;
    in_x    = (col_e >= start_x) && (off_x < len_x);
    in_y    = (row_e >= start_y) && (off_y < len_y);
    on_x    = in_x && (ph_xe == '0);
    on_y    = in_y && (ph_ye == '0);
    reach_x = 14'(off_x) + 14'(step_x);
    line_end  = (col_e >= wm1);
    frame_end = line_end && (row_e >= hm1);

    push_item.pix     = in_pix;
    push_item.kx      = k_xe;
    push_item.row_sel = k_ye[0];
    push_item.wr      = on_x && on_y && (9'(k_xe) < 9'(LVFS_SLOTS));
    push_item.smp     = push_item.wr && (k_ye >= LVFS_K_W'(2)) && (k_xe != '0) &&
                        (reach_x < 14'(len_x)) && (9'(k_xe) + 9'd1 < 9'(LVFS_SLOTS));
    push_item.clr     = in_start;
    push_item.last    = frame_end;
  end

  // Advance the lattice phase along each axis
  always_comb begin
    ph_x_next = ph_xe;
    k_x_next  = k_xe;
    if (in_x) begin
      if (ph_xe + LVFS_STEP_W'(1) == step_x) begin
        ph_x_next = '0;
        k_x_next  = k_xe + LVFS_K_W'(1);
      end else begin
        ph_x_next = ph_xe + LVFS_STEP_W'(1);
      end
    end
    ph_y_next = ph_ye;
    k_y_next  = k_ye;
    if (in_y) begin
      if (ph_ye + LVFS_STEP_W'(1) == step_y) begin
        ph_y_next = '0;
        k_y_next  = k_ye + LVFS_K_W'(1);
      end else begin
        ph_y_next = ph_ye + LVFS_STEP_W'(1);
      end
    end
  end

  // Step the raster position on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      ph_x <= '0;
      ph_y <= '0;
      k_x  <= '0;
      k_y  <= '0;
    end else if (push) begin
      if (line_end) begin
        col  <= '0;
        ph_x <= '0;
        k_x  <= '0;
        if (frame_end) begin
          row  <= '0;
          ph_y <= '0;
          k_y  <= '0;
        end else begin
          row  <= row_e + LVFS_POS_W'(1);
          ph_y <= ph_y_next;
          k_y  <= k_y_next;
        end
      end else begin
        col  <= col_e + LVFS_POS_W'(1);
        ph_x <= ph_x_next;
        k_x  <= k_x_next;
        row  <= row_e;
        ph_y <= ph_ye;
        k_y  <= k_ye;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/lvfs_fifo.sv */
// ----------------------------------------------------------------------------
// lvfs_fifo - four-entry queue of classified pixels
// Decouples the pixel front from the arithmetic back.
// ----------------------------------------------------------------------------
`default_nettype none
module lvfs_fifo import lvfs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  lvfs_item_t push_item,
  input  wire logic  pop,
  output lvfs_item_t head,
  output logic       full,
  output logic       empty
);

  lvfs_item_t  slots [4];
  logic [1:0]  wp, rp;
  logic [2:0]  count;

  assign full  = (count == 3'd4);
  assign empty = (count == 3'd0);
  assign head  = slots[rp];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_item;
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop)  rp <= rp + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/lvfs_back.sv */
// ----------------------------------------------------------------------------
// lvfs_back - lattice row store, Laplacian accumulation and frame score
// Forms samples from the stored rows and divides out the variance per frame.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lvfs_back import lvfs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] min_sample_count,
  input  lvfs_item_t       head,
  input  wire logic        empty,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [47:0]      out_data,
  output logic             out_flag
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ITEM = 4'd1;
  localparam logic [3:0] S_RD2  = 4'd2;
  localparam logic [3:0] S_LAP  = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_F0   = 4'd5;
  localparam logic [3:0] S_F1   = 4'd6;
  localparam logic [3:0] S_F2   = 4'd7;
  localparam logic [3:0] S_F3   = 4'd8;
  localparam logic [3:0] S_F4   = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]  state;
  lvfs_item_t  item;

  logic [7:0]             mem [LVFS_DEPTH];
  logic [LVFS_ADDR_W-1:0] ra0, ra1, wa, cur_base, prev_base;
  logic [7:0]             rd0, rd1, wd, left_px, mid_px;
  logic                   we;

  logic signed [10:0] lap;
  logic signed [11:0] lap_w;
  logic signed [21:0] lap_sq;
  logic signed [26:0] sum;
  logic [35:0]        sumsq;
  logic [15:0]        n;
  logic               valid;
  logic [25:0]        mag;
  logic [51:0]        msq;
  logic [31:0]        nn;
  logic [33:0]        plo, phi;
  logic [59:0]        dvd;
  logic [32:0]        rem, rem_sh;
  logic [5:0]         cnt;
  logic               direct;
  logic               out_load;

  // Handle pixels that need no sample straight from the queue head
  assign direct = !head.smp && !head.last;
  assign pop    = (state == S_IDLE) && !empty;

  // Load a result when the output register is free or being emptied
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  // Row store addressing
  always_comb begin
    cur_base  = item.row_sel ? LVFS_ADDR_W'(LVFS_SLOTS) : '0;
    prev_base = item.row_sel ? '0 : LVFS_ADDR_W'(LVFS_SLOTS);
    ra0 = prev_base + LVFS_ADDR_W'(item.kx) - LVFS_ADDR_W'(1);
    ra1 = prev_base + LVFS_ADDR_W'(item.kx);
    if (state == S_RD2) begin
      ra0 = prev_base + LVFS_ADDR_W'(item.kx) + LVFS_ADDR_W'(1);
      ra1 = cur_base + LVFS_ADDR_W'(item.kx);
    end
    we = 1'b0;
    wa = cur_base + LVFS_ADDR_W'(item.kx);
    wd = item.pix;
    if (pop && direct) begin
      we = head.wr;
      wa = (head.row_sel ? LVFS_ADDR_W'(LVFS_SLOTS) : '0) + LVFS_ADDR_W'(head.kx);
      wd = head.pix;
    end else if (state == S_ITEM) begin
      we = item.wr && !item.smp;
    end else if (state == S_LAP) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  // Laplacian and magnitude of the sum
  assign lap_w  = $signed({2'b00, mid_px, 2'b00}) - $signed({4'b0, left_px})
                - $signed({4'b0, rd0}) - $signed({4'b0, rd1}) - $signed({4'b0, item.pix});
  assign lap_sq = lap * lap;
  assign mag    = sum[26] ? 26'(-sum) : sum[25:0];
  assign rem_sh = {rem[31:0], dvd[59]};

  // Sequence samples and the end-of-frame score
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sum       <= '0;
      sumsq     <= '0;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            item <= head;
            if (head.clr) begin
              sum   <= '0;
              sumsq <= '0;
              n     <= '0;
            end
            if (!direct) state <= S_ITEM;
          end
        end
        S_ITEM: begin
          if (item.smp) state <= S_RD2;
          else          state <= item.last ? S_F0 : S_IDLE;
        end
        S_RD2: begin
          left_px <= rd0;
          mid_px  <= rd1;
          state   <= S_LAP;
        end
        S_LAP: begin
          lap   <= lap_w[10:0];
          state <= S_ACC;
        end
        S_ACC: begin
          sum   <= sum + 27'(lap);
          sumsq <= sumsq + 36'(lap_sq[19:0]);
          n     <= n + 16'd1;
          state <= item.last ? S_F0 : S_IDLE;
        end
        S_F0: begin
          valid <= (n != 16'd0) && (n >= min_sample_count);
          msq   <= 52'(mag) * 52'(mag);
          state <= ((n != 16'd0) && (n >= min_sample_count)) ? S_F1 : S_OUT;
        end
        S_F1: begin
          nn    <= 32'(n) * 32'(n);
          state <= S_F2;
        end
        S_F2: begin
          plo   <= 34'(n) * 34'(sumsq[17:0]);
          state <= S_F3;
        end
        S_F3: begin
          phi   <= 34'(n) * 34'(sumsq[35:18]);
          state <= S_F4;
        end
        S_F4: begin
          dvd   <= {52'({phi, 18'b0}) + 52'(plo) - msq, 8'b0};
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle
          if (rem_sh >= 33'(nn)) begin
            rem <= rem_sh - 33'(nn);
            dvd <= {dvd[58:0], 1'b1};
          end else begin
            rem <= rem_sh;
            dvd <= {dvd[58:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd59) state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            out_flag  <= valid;
            out_data  <= {3'b0, n, valid ? dvd[28:0] : 29'd0};
            sum       <= '0;
            sumsq     <= '0;
            n         <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LVFS_ASSERT_IMPL(a_div_nonzero, state == S_DIV, nn != 32'd0, "divide by zero sample count")
  `LVFS_ASSERT_IMPL(a_invalid_zero, out_valid && !out_flag, out_data[28:0] == 29'd0, "invalid score not zero")
  `LVFS_ASSERT_IMPL(a_no_pop_busy, pop, state == S_IDLE && !empty, "queue popped while busy")
  `LVFS_ASSERT(a_out_clear, (state == S_OUT && (!out_valid || out_ready)) |=> (n == 16'd0 && state == S_IDLE), "accumulators not cleared after result")

endmodule
`default_nettype wire

/* rtl/laplacian_variance_focus_score_unit.sv */
// ----------------------------------------------------------------------------
// laplacian_variance_focus_score_unit - focus score of a luma frame
// Variance of the 4-neighbour Laplacian over a decimated center lattice.
// ----------------------------------------------------------------------------
// Pixels stream in raster order and enter a four-deep queue at up to one per
// cycle; the input is held off after each register write while the crop
// geometry is recomputed. The back end retires a pixel off the sample set
// from the queue head, a Laplacian sample through ITEM, RD2, LAP and ACC (two
// registered reads of the lattice row memory, the Laplacian, the accumulate).
// At frame end it forms the score in F0, then for a valid score F1 to F4 and
// the bit-serial divider, then holds one result on the master side until taken.
`default_nettype none
module laplacian_variance_focus_score_unit import lvfs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // Pixel input
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] luma_pixel
  input  wire logic        s_tuser,   // [0] frame_start
  // Score output
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [28:0] focus_score, [44:29] sample_total
  output logic             m_tuser,   // [0] score_valid
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [13:0] frame_width, frame_height;
  logic [15:0] min_sample_count;
  logic        cfg_wr;
  logic        push, pop, q_full, q_empty;
  lvfs_item_t  push_item, head;

  // Register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= 14'd1920;
      frame_height     <= 14'd1080;
      min_sample_count <= 16'd16;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FRAME_WIDTH:  frame_width      <= pwdata[13:0];
        REG_FRAME_HEIGHT: frame_height     <= pwdata[13:0];
        REG_MIN_SAMPLES:  min_sample_count <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[3:2])
      REG_FRAME_WIDTH:  prdata = {18'b0, frame_width};
      REG_FRAME_HEIGHT: prdata = {18'b0, frame_height};
      REG_MIN_SAMPLES:  prdata = {16'b0, min_sample_count};
      default:          prdata = '0;
    endcase
  end

  lvfs_front u_front (
    .clk, .rst,
    .frame_width, .frame_height,
    .cfg_wr,
    .in_valid (s_tvalid),
    .in_pix   (s_tdata),
    .in_start (s_tuser),
    .q_full,
    .in_ready (s_tready),
    .push,
    .push_item
  );

  lvfs_fifo u_fifo (
    .clk, .rst,
    .push, .push_item,
    .pop, .head,
    .full  (q_full),
    .empty (q_empty)
  );

  lvfs_back u_back (
    .clk, .rst,
    .min_sample_count,
    .head,
    .empty     (q_empty),
    .pop,
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_flag  (m_tuser)
  );

endmodule
`default_nettype wire

/* tb/laplacian_variance_focus_score_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_variance_focus_score_unit_tb - self-checking bench of the focus unit
// Streams luma frames of many geometries through the pixel port under
// several handshake idling mixes, predicts each frame's Laplacian variance
// score in the bench and compares every score transfer field by field.
// ----------------------------------------------------------------------------
module laplacian_variance_focus_score_unit_tb import lvfs_pkg::*; ();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES = 2000;

  typedef enum int {PAT_FLAT, PAT_CHECK, PAT_RAND, PAT_RAMP} pattern_e;

  typedef struct {
    logic [28:0] score;
    logic        valid;
    logic [15:0] total;
  } focus_result_t;

  typedef struct {
    int unsigned w;
    int unsigned h;
    int unsigned min_cnt;
    pattern_e    pat;
    int unsigned level;
    int unsigned cut;      // pixels of an aborted frame sent ahead
    bit          fixed;    // expected result typed in below
    int unsigned score;
    bit          valid;
    int unsigned total;
  } frame_case_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  laplacian_variance_focus_score_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Mirror of the block state
  int unsigned   cfg_w, cfg_h, cfg_min;
  int unsigned   col_pos, row_pos;
  byte unsigned  lattice_rows [2*LVFS_SLOTS];
  longint        lap_sum;
  longint unsigned lap_sq_sum;
  int unsigned   sample_cnt;
  focus_result_t score_q [$];

  int  fail_cnt = 0;
  int  result_cnt = 0;
  int  cycle_cnt = 0;
  int  send_pct = 0;
  int  stall_pct = 0;
  bit  hold_go = 1'b0;

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > LVFS_DIM_MAX) return LVFS_DIM_MAX;
    return v;
  endfunction

  // Lattice index and span of a position along one axis
  function automatic bit lattice_pos(input int unsigned pos, input int unsigned dim,
                                     output int unsigned idx, output int unsigned span);
    int unsigned start, len, stride, off;
    start = dim / 4;
    len = dim / 2;
    stride = len / LVFS_SPAN;
    if (stride == 0) stride = 1;
    span = (len + stride - 1) / stride;
    idx = 0;
    if (pos < start) return 1'b0;
    off = pos - start;
    if (off >= len || (off % stride) != 0) return 1'b0;
    idx = off / stride;
    return 1'b1;
  endfunction

  function automatic void clear_frame();
    col_pos = 0;
    row_pos = 0;
    lap_sum = 0;
    lap_sq_sum = 0;
    sample_cnt = 0;
  endfunction

  // Advance the mirror by one accepted pixel, queue a score at frame end
  function automatic void predict_pixel(byte unsigned pix, bit fs);
    int unsigned w, h, kx, ky, lx, ly, cur, prv;
    bit on_x, on_y, done;
    int lap;
    longint unsigned n, mag, num, q, r, t;
    focus_result_t res;
    w = clamp_dim(cfg_w);
    h = clamp_dim(cfg_h);
    if (fs) clear_frame();
    on_x = lattice_pos(col_pos, w, kx, lx);
    on_y = lattice_pos(row_pos, h, ky, ly);
    if (on_x && on_y && kx < LVFS_SLOTS) begin
      cur = (ky & 1) * LVFS_SLOTS;
      prv = ((ky + 1) & 1) * LVFS_SLOTS;
      if (ky >= 2 && kx >= 1 && kx + 1 < lx && kx + 1 < LVFS_SLOTS) begin
        lap = 4 * int'(lattice_rows[prv+kx]) - int'(lattice_rows[prv+kx-1])
            - int'(lattice_rows[prv+kx+1]) - int'(lattice_rows[cur+kx]) - int'(pix);
        lap_sum += lap;
        lap_sq_sum += longint'(lap) * longint'(lap);
        sample_cnt++;
      end
      lattice_rows[cur+kx] = pix;
    end
    done = 1'b0;
    if (col_pos >= w - 1) begin
      col_pos = 0;
      if (row_pos >= h - 1) done = 1'b1;
      else row_pos++;
    end else begin
      col_pos++;
    end
    if (!done) return;
    n = sample_cnt;
    res.valid = (n > 0) && (n >= cfg_min);
    res.score = '0;
    if (res.valid) begin
      mag = (lap_sum < 0) ? longint'(-lap_sum) : longint'(lap_sum);
      num = n * lap_sq_sum - mag * mag;
      q = num / n;
      r = num % n;
      t = q * 256 + (r * 256) / n;
      res.score = 29'(t / n);
    end
    res.total = (n > 65535) ? 16'hFFFF : 16'(n);
    score_q.push_back(res);
    clear_frame();
  endfunction

  // APB write: setup cycle, then access cycle
  task automatic reg_write(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  cfg_w = val & 32'h3FFF;
      REG_FRAME_HEIGHT: cfg_h = val & 32'h3FFF;
      REG_MIN_SAMPLES:  cfg_min = val & 32'hFFFF;
      default: ;
    endcase
  endtask

  // Drain every pending score, then let the pipeline go quiet
  task automatic settle();
    while (score_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stop offering pixels before the registers change
  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned min_cnt);
    s_tvalid <= 1'b0;
    settle();
    reg_write(REG_FRAME_WIDTH, w);
    reg_write(REG_FRAME_HEIGHT, h);
    reg_write(REG_MIN_SAMPLES, min_cnt);
  endtask

  task automatic send_pixel(byte unsigned pix, bit fs);
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    s_tuser <= fs;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_pixel(pix, fs);
  endtask

  function automatic byte unsigned pattern_pixel(pattern_e pat, int unsigned level,
                                                 int unsigned x, int unsigned y);
    case (pat)
      PAT_FLAT:  return 8'(level);
      PAT_CHECK: return ((x + y) & 1) ? 8'hFF : 8'h00;
      PAT_RAMP:  return 8'(x * 37 + y * 11);
      default:   return (level != 0 && $urandom_range(3) == 0)
                        ? (($urandom_range(1) != 0) ? 8'hFF : 8'h00)
                        : 8'($urandom_range(255));
    endcase
  endfunction

  // Send pixels of one frame; a nonzero count stops early to leave it aborted
  task automatic send_frame(pattern_e pat, int unsigned level, bit fs, int unsigned count);
    int unsigned w, h, x, y, k;
    w = clamp_dim(cfg_w);
    h = clamp_dim(cfg_h);
    k = 0;
    for (y = 0; y < h; y++) begin
      for (x = 0; x < w; x++) begin
        if (count != 0 && k == count) return;
        send_pixel(pattern_pixel(pat, level, x, y), fs && k == 0);
        k++;
      end
    end
  endtask

  // Directed frames: flat, checker, random, ramp, an aborted frame, extremes of geometry and threshold
  frame_case_t frame_cases [] = '{
    '{8, 8, 16, PAT_FLAT, 255, 0, 1, 0, 0, 4},
    '{8, 8, 0, PAT_FLAT, 0, 0, 1, 0, 1, 4},
    '{8, 8, 0, PAT_CHECK, 0, 0, 0, 0, 0, 0},
    '{12, 10, 0, PAT_RAND, 0, 0, 0, 0, 0, 0},
    '{5, 8, 0, PAT_RAND, 0, 0, 1, 0, 0, 0},
    '{0, 0, 0, PAT_RAND, 0, 0, 1, 0, 0, 0},
    '{6, 6, 1, PAT_RAMP, 0, 0, 0, 0, 0, 0},
    '{8, 8, 65535, PAT_RAND, 0, 0, 1, 0, 0, 4},
    '{9, 9, 3, PAT_CHECK, 0, 17, 0, 0, 0, 0},
    '{100, 6, 1, PAT_RAND, 1, 0, 0, 0, 0, 0},
    '{2, 1, 0, PAT_FLAT, 7, 0, 1, 0, 0, 0},
    '{11, 7, 2, PAT_RAND, 1, 0, 0, 0, 0, 0}
  };

  // Receiver: random stalls, plus one long hold-off to back the block up
  always @(posedge clk) begin : score_sink
    int hold_left;
    bit hold_seen;
    if (rst) begin
      hold_left = 0;
      hold_seen = 1'b0;
    end else if (hold_go && !hold_seen) begin
      hold_left = HOLD_CYCLES;
      hold_seen = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
    end
  end

  // Compare each score transfer with the oldest expected score
  always @(posedge clk) begin
    focus_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (score_q.size() == 0) begin
        $error("unexpected score transfer: tdata %h tuser %b", m_tdata, m_tuser);
        fail_cnt++;
      end else begin
        exp_res = score_q.pop_front();
        result_cnt++;
        if (m_tdata[28:0] !== exp_res.score) begin
          $error("focus_score expected %0d actual %0d", exp_res.score, m_tdata[28:0]);
          fail_cnt++;
        end
        if (m_tuser !== exp_res.valid) begin
          $error("score_valid expected %0d actual %0d", exp_res.valid, m_tuser);
          fail_cnt++;
        end
        if (m_tdata[44:29] !== exp_res.total) begin
          $error("sample_total expected %0d actual %0d", exp_res.total, m_tdata[44:29]);
          fail_cnt++;
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("laplacian_variance_focus_score_unit_tb failed");
      $finish;
    end
  end

  initial begin
    int unsigned sent, phase, frames, w, h, cut;
    bit fs;
    cfg_w = 1920;
    cfg_h = 1080;
    cfg_min = 16;
    foreach (lattice_rows[i]) lattice_rows[i] = 0;
    clear_frame();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed frames; fixed rows replace the predicted result with the typed one
    sent = 0;
    foreach (frame_cases[i]) begin
      set_geometry(frame_cases[i].w, frame_cases[i].h, frame_cases[i].min_cnt);
      if (frame_cases[i].cut != 0)
        send_frame(frame_cases[i].pat, frame_cases[i].level, 1'b1, frame_cases[i].cut);
      send_frame(frame_cases[i].pat, frame_cases[i].level, 1'b1, 0);
      sent += clamp_dim(frame_cases[i].w) * clamp_dim(frame_cases[i].h) + frame_cases[i].cut;
      if (frame_cases[i].fixed) begin
        score_q[$].score = frame_cases[i].score;
        score_q[$].valid = frame_cases[i].valid;
        score_q[$].total = frame_cases[i].total;
      end
    end

    // Random frames in phases of idling mix; small frames keep scores frequent
    phase = 0;
    while (phase < 4 || sent < 1750) begin
      set_geometry(0, 0, 0);
      w = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 11);
      h = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 11);
      case ($urandom_range(5))
        0:       reg_write(REG_MIN_SAMPLES, 0);
        1:       reg_write(REG_MIN_SAMPLES, 65535);
        default: reg_write(REG_MIN_SAMPLES, $urandom_range(12));
      endcase
      reg_write(REG_FRAME_WIDTH, w);
      reg_write(REG_FRAME_HEIGHT, h);
      case (phase % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 50; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 50; end
        default: begin send_pct = 9; stall_pct = 9; end
      endcase
      if (phase == 0) hold_go <= 1'b1;
      for (frames = 0; frames < 3; frames++) begin
        fs = 1'($urandom_range(1));
        // Restart with a frame start after an aborted frame
        if ($urandom_range(7) == 0) begin
          cut = $urandom_range(1, clamp_dim(w) * clamp_dim(h));
          send_frame(PAT_RAND, 1, 1'b1, cut);
          sent += cut;
          fs = 1'b1;
        end
        send_frame(($urandom_range(9) == 0) ? PAT_CHECK : PAT_RAND, $urandom_range(1),
                   fs, 0);
        sent += clamp_dim(w) * clamp_dim(h);
      end
      phase++;
    end
    s_tvalid <= 1'b0;

    settle();
    if (fail_cnt == 0) begin
      $display("laplacian_variance_focus_score_unit_tb passed");
    end else begin
      $display("laplacian_variance_focus_score_unit_tb failed");
    end
    $finish;
  end

endmodule
